[hw/rtl/deq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the double-ended queue with search.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_BACK   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_FIND       = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] position;
    logic [4:0] occupancy;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic step;    // advance the search by one entry
    logic load;    // capture the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_find;  // request at the port is a find
    logic empty;    // queue holds no entry
    logic hit;      // entry under compare equals the key
    logic last;     // entry under compare is the back entry
  } ctrl_sts_t;

endpackage
`default_nettype wire

[hw/rtl/deq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_datapath
// Ring-buffer storage, front index, entry count, search key and compare,
// and the result register.
// ----------------------------------------------------------------------------
module deq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire deq_pkg::req_t        request,
  input  wire deq_pkg::ctrl_cmd_t   cmd,
  output deq_pkg::ctrl_sts_t        sts,
  output deq_pkg::res_t             result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] rd_k;

  logic [IW-1:0] front;
  logic [IW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] cmp_idx;
  logic [CW-1:0] cmp_idx_inc;
  logic [31:0]   key;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] front_dec;
  logic          full;

  deq_pkg::res_t result_next;

  // Slot of the entry k places behind the front, wrapped into the ring
  function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
                                              input logic [CW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(k);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return IW'(sum);
  endfunction

  assign full        = (count == DEPTH_C);
  assign front_dec   = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign cmp_idx_inc = cmp_idx + 1'b1;

  assign sts.is_find = (request.command == deq_pkg::CMD_FIND);
  assign sts.empty   = (count == '0);
  assign sts.hit     = (rd_data == key);
  assign sts.last    = (cmp_idx_inc == count);

  // Accept reads the front entry; each search step reads the one after it
  assign rd_k    = cmd.accept ? '0 : cmp_idx_inc;
  assign rd_addr = ring_slot(front, rd_k);

  always_comb begin
    front_next  = front;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = ring_slot(front, count);
    result_next.status   = deq_pkg::ST_DONE;
    result_next.found    = 1'b0;
    result_next.position = '0;
    if (cmd.accept) begin
      unique case (request.command)
        deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            result_next.status = deq_pkg::ST_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end
        end
        deq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            result_next.status = deq_pkg::ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = front_dec;
            front_next = front_dec;
            count_next = count + 1'b1;
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (sts.empty) begin
            result_next.status = deq_pkg::ST_EMPTY;
          end else begin
            count_next = count - 1'b1;
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (sts.empty) begin
            result_next.status = deq_pkg::ST_EMPTY;
          end else begin
            front_next = (front == LAST_SLOT) ? '0 : front + 1'b1;
            count_next = count - 1'b1;
          end
        end
        deq_pkg::CMD_FIND: begin
          // only loaded here when the queue is empty
          result_next.status = deq_pkg::ST_MISSING;
        end
        default: begin
        end
      endcase
    end else if (sts.hit) begin
      result_next.found    = 1'b1;
      result_next.position = 4'(cmp_idx);
    end else begin
      result_next.status = deq_pkg::ST_MISSING;
    end
    result_next.occupancy = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= request.value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key     <= request.value;
      cmp_idx <= '0;
    end else if (cmd.step) begin
      cmp_idx <= cmp_idx_inc;
    end
    if (cmd.load) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/deq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Request handshake and search sequencer of the double-ended queue.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire deq_pkg::ctrl_sts_t   sts,
  output deq_pkg::ctrl_cmd_t        cmd,
  output logic                      busy,
  output logic                      done
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state;
  logic state_next;
  logic done_next;

  assign busy = (state == S_SCAN);

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    cmd.load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.is_find && !sts.empty) begin
            state_next = S_SCAN;
          end else begin
            cmd.load  = 1'b1;
            done_next = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // finish on the first match or after the back entry
        if (sts.hit || sts.last) begin
          cmd.load   = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/double_ended_queue_with_search_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_top
// Double-ended queue of 32-bit values in a ring buffer of DEPTH entries,
// with push and pop at both ends and a search from the front.
//
//   channel  | ports           | handshake
//   ---------+-----------------+-------------------------------------------
//   request  | request         | taken at a clock edge with start & !busy
//   result   | result          | valid for the single cycle done is high
//
// Push, pop, unused commands and a find on an empty queue: result in the cycle
// after the request, busy stays low, so a request may be taken every cycle.
// Find on a filled queue: one stored entry compared per cycle through the
// memory's registered read port; busy stays high until the result is loaded,
// on the first match or after the back entry.
// Synchronous reset empties the queue; the storage itself is not cleared.
// The receiver cannot stall: each result is shown once, for one cycle.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_top #(
  parameter int DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire deq_pkg::req_t   request,
  output logic                 busy,
  output logic                 done,
  output deq_pkg::res_t        result
);

  deq_pkg::ctrl_cmd_t cmd;
  deq_pkg::ctrl_sts_t sts;

  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the double-ended queue with search against a local mirror of the
// ring buffer. Each accepted request updates the mirror and queues the
// answer it must produce. Every done strobe is compared field by field with
// the oldest queued answer. Stimulus: empty and full corner cases, then random
// traffic that drifts between filling and draining, under varying sender
// gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 300000;

  localparam logic [31:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0000_0001, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h1234_5678
  };

  logic clk = 1'b0;
  logic rst;
  logic start;
  deq_pkg::req_t request;
  logic busy;
  logic done;
  deq_pkg::res_t result;

  // mirror of the queue contents
  logic signed [31:0] mirror_slots [DEPTH];
  logic [3:0]         mirror_front;
  logic [4:0]         mirror_count;

  deq_pkg::res_t answers_due [$];
  int   mismatch_count = 0;
  int   idle_pct;
  int   cycle_count = 0;

  double_ended_queue_with_search_top #(.DEPTH(DEPTH)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the mirror and return the answer it must produce.
  function automatic deq_pkg::res_t predict_answer(deq_pkg::req_t req);
    deq_pkg::res_t ans;
    ans = '{status: deq_pkg::ST_DONE, found: 1'b0, position: 4'd0, occupancy: 5'd0};
    case (req.command)
      deq_pkg::CMD_PUSH_BACK, deq_pkg::CMD_PUSH_FRONT: begin
        if (mirror_count == 5'(DEPTH)) begin
          ans.status = deq_pkg::ST_FULL;
        end else if (req.command == deq_pkg::CMD_PUSH_BACK) begin
          mirror_slots[4'(mirror_front + mirror_count)] = req.value;
          mirror_count = mirror_count + 5'd1;
        end else begin
          mirror_front = mirror_front - 4'd1;
          mirror_slots[mirror_front] = req.value;
          mirror_count = mirror_count + 5'd1;
        end
      end
      deq_pkg::CMD_POP_BACK, deq_pkg::CMD_POP_FRONT: begin
        if (mirror_count == 5'd0) begin
          ans.status = deq_pkg::ST_EMPTY;
        end else begin
          if (req.command == deq_pkg::CMD_POP_FRONT) mirror_front = mirror_front + 4'd1;
          mirror_count = mirror_count - 5'd1;
        end
      end
      deq_pkg::CMD_FIND: begin
        ans.status = deq_pkg::ST_MISSING;
        for (int k = 0; k < int'(mirror_count); k++) begin
          if (mirror_slots[4'(mirror_front + k)] == req.value) begin
            ans.status   = deq_pkg::ST_DONE;
            ans.found    = 1'b1;
            ans.position = 4'(k);
            break;
          end
        end
      end
      default: ;  // unused codes leave the queue alone
    endcase
    ans.occupancy = mirror_count;
    return ans;
  endfunction

  task automatic send_request(input logic [2:0] cmd, input logic [31:0] val);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= '{command: cmd, value: val};
    // hold the request until an edge finds the block free
    do @(posedge clk); while (busy);
    answers_due.push_back(predict_answer('{command: cmd, value: val}));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 2) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(bit for_find);
    int r;
    r = $urandom_range(99);
    if (for_find && mirror_count != 5'd0 && r < 50)
      return mirror_slots[4'(mirror_front + $urandom_range(int'(mirror_count) - 1))];
    if (r < 70) return VALUE_POOL[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_command(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 4) return 3'($urandom_range(5, 7));
    if (r < (filling ? 60 : 24)) begin
      return $urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK;
    end
    if (r < (filling ? 75 : 74)) begin
      return $urandom_range(1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
    end
    return deq_pkg::CMD_FIND;
  endfunction

  task automatic test_empty_queue();
    send_request(deq_pkg::CMD_POP_BACK, 32'h0);
    send_request(deq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_request(deq_pkg::CMD_FIND, 32'h0);
    send_request(3'd5, 32'h1);
    send_request(3'd7, 32'h8000_0000);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++)
      send_request(i[0] ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK,
                   (i < 8) ? VALUE_POOL[i] : 32'(i * 32'h0101_0101));
    send_request(deq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_request(3'd6, 32'hFFFF_FFFF);
    send_request(deq_pkg::CMD_FIND, 32'h0F0F_0F0F);   // front entry
    send_request(deq_pkg::CMD_FIND, 32'h0E0E_0E0E);   // back entry
    send_request(deq_pkg::CMD_FIND, 32'hDEAD_BEEF);   // absent
    send_request(deq_pkg::CMD_POP_FRONT, 32'h0);
    send_request(deq_pkg::CMD_POP_BACK, 32'h0);
  endtask

  task automatic test_random_traffic(input int count, input int gap_pct);
    bit filling;
    int run_left;
    logic [2:0] cmd;
    filling  = 1'b1;
    run_left = 0;
    idle_pct = gap_pct;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        filling  = ~filling;
        run_left = $urandom_range(20, 60);
      end
      run_left = run_left - 1;
      cmd = pick_command(filling);
      send_request(cmd, pick_value(cmd == deq_pkg::CMD_FIND));
    end
  endtask

  // Compare every done strobe with the oldest queued answer.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        mismatch_count++;
      end else begin
        deq_pkg::res_t want;
        want = answers_due.pop_front();
        if (result.status !== want.status || result.found !== want.found ||
            result.position !== want.position || result.occupancy !== want.occupancy) begin
          $display("%0t: mismatch expected status %0d found %0d position %0d occupancy %0d,",
                   $time, want.status, want.found, want.position, want.occupancy);
          $display("%0t:          actual   status %0d found %0d position %0d occupancy %0d",
                   $time, result.status, result.found, result.position, result.occupancy);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[double_ended_queue_with_search_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    request        <= '0;
    mirror_front   = 4'd0;
    mirror_count   = 5'd0;
    idle_pct       = 28;
    for (int i = 0; i < DEPTH; i++) mirror_slots[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_full_queue();
    wait_drained();
    test_random_traffic(250, 28);
    wait_drained();
    test_random_traffic(250, 66);
    wait_drained();
    test_random_traffic(250, 0);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("[double_ended_queue_with_search_top] OK");
    end else begin
      $display("[double_ended_queue_with_search_top] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/deq_pkg.sv
hw/rtl/deq_datapath.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_with_search_top.sv
tb/sv/testbench.sv
